// ===== rtl/rmcf_pkg.sv =====
// Shared types and constants for the region mean colour fill block.
// Used by rmcf_table, rmcf_div_lane and region_mean_color_fill_top; no dependencies.
`timescale 1ns / 1ps

package rmcf_pkg;

    localparam int LABEL_BITS  = 10;
    localparam int LABEL_COUNT = 2 ** LABEL_BITS;
    localparam int COUNT_BITS  = 22;
    localparam int CHAN_BITS   = 8;
    localparam int EPOCH_BITS  = 8;
    localparam int OP_BITS     = 2;
    localparam int STEP_BITS   = $clog2(CHAN_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;
    localparam logic [LABEL_BITS-1:0] LABEL_LAST = '1;
    localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(CHAN_BITS - 1);

    typedef logic [OP_BITS-1:0] op_t;

    localparam op_t OP_ACCUM = 2'd0;
    localparam op_t OP_PAINT = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [COUNT_BITS-1:0] count;
        logic [CHAN_BITS-1:0]  red;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  blue;
    } entry_t;

    typedef struct packed {
        op_t                   op;
        logic [LABEL_BITS-1:0] label;
        logic [CHAN_BITS-1:0]  blue;
        logic [CHAN_BITS-1:0]  green;
        logic [CHAN_BITS-1:0]  red;
        logic                  contour;
    } item_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PAINT,
        ST_DIV,
        ST_WRITE
    } state_t;

endpackage

// ===== rtl/region_mean_color_fill_top.sv =====
// Top level of the region mean colour fill block: sequencer, item and output registers.
// Instantiates rmcf_table and three rmcf_div_lane units; depends on rmcf_pkg.
//
// Channel  Direction  Word contents
// s_       in         label, pixel blue/green/red in tdata; op and on_contour in tuser
// m_       out        paint blue/green/red in tdata, one word per paint item
//
// An accumulate item passes through accept, table read, 8 divider steps (one
// quotient bit per cycle, all three channels together) and the table write.
// A paint item is accepted and read, then waits for the output register to empty.
// A clear item just advances the frame tag; every 255th clear, and reset, run a
// clearing pass over all 1024 table entries with s_tready low.
// The output register holds a finished word while the next item is taken.
`timescale 1ns / 1ps

module region_mean_color_fill_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // label[9:0], blue[17:10], green[25:18], red[33:26]
    input  logic [2:0]  s_tuser,  // op[1:0], on_contour[2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // paint_blue[7:0], paint_green[15:8], paint_red[23:16]
);

    localparam int CB = rmcf_pkg::CHAN_BITS;

    rmcf_pkg::state_t state_reg, state_next;
    rmcf_pkg::item_t  item_reg, item_next;
    logic [rmcf_pkg::EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [rmcf_pkg::LABEL_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [rmcf_pkg::STEP_BITS-1:0]  step_reg, step_next;
    logic [rmcf_pkg::COUNT_BITS-1:0] n_reg, n_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    logic                            accept;
    logic                            out_free;
    logic                            load_out;
    logic                            hit;
    logic [rmcf_pkg::COUNT_BITS-1:0] cur_count;
    logic [rmcf_pkg::COUNT_BITS-1:0] n_new;
    logic [CB-1:0]                   cur_blue, cur_green, cur_red;
    logic [CB-1:0]                   res_blue, res_green, res_red;
    rmcf_pkg::lane_ctrl_t            lane_ctrl;
    rmcf_pkg::entry_t                rd_data;
    rmcf_pkg::entry_t                wr_data;
    logic                            wr_en;
    logic [rmcf_pkg::LABEL_BITS-1:0] wr_addr;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign hit       = rd_data.tag == epoch_reg;
    assign cur_count = hit ? rd_data.count : '0;
    assign cur_blue  = hit ? rd_data.blue  : '0;
    assign cur_green = hit ? rd_data.green : '0;
    assign cur_red   = hit ? rd_data.red   : '0;
    assign n_new     = (cur_count == rmcf_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rmcf_pkg::ST_CLEAR: begin
                if (clr_idx_reg == rmcf_pkg::LABEL_LAST) begin
                    state_next = rmcf_pkg::ST_IDLE;
                end
            end
            rmcf_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (item_next.op)
                        rmcf_pkg::OP_ACCUM, rmcf_pkg::OP_PAINT: begin
                            state_next = rmcf_pkg::ST_READ;
                        end
                        rmcf_pkg::OP_CLEAR: begin
                            if (epoch_reg == rmcf_pkg::EPOCH_LAST) begin
                                state_next = rmcf_pkg::ST_CLEAR;
                            end
                        end
                        default: begin
                            state_next = rmcf_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            rmcf_pkg::ST_READ: begin
                state_next = (item_reg.op == rmcf_pkg::OP_PAINT) ? rmcf_pkg::ST_PAINT
                                                                  : rmcf_pkg::ST_DIV;
            end
            rmcf_pkg::ST_PAINT: begin
                if (out_free) begin
                    state_next = rmcf_pkg::ST_IDLE;
                end
            end
            rmcf_pkg::ST_DIV: begin
                if (step_reg == rmcf_pkg::STEP_LAST) begin
                    state_next = rmcf_pkg::ST_WRITE;
                end
            end
            rmcf_pkg::ST_WRITE: begin
                state_next = rmcf_pkg::ST_IDLE;
            end
            default: begin
                state_next = rmcf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        lane_ctrl.load = 1'b0;
        lane_ctrl.step = 1'b0;
        load_out       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = item_reg.label;
        wr_data.tag    = epoch_reg;
        wr_data.count  = n_reg;
        wr_data.blue   = res_blue;
        wr_data.green  = res_green;
        wr_data.red    = res_red;
        unique case (state_reg)
            rmcf_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = '0;
            end
            rmcf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            rmcf_pkg::ST_READ: begin
                lane_ctrl.load = 1'b1;
            end
            rmcf_pkg::ST_PAINT: begin
                load_out = out_free;
            end
            rmcf_pkg::ST_DIV: begin
                lane_ctrl.step = 1'b1;
            end
            rmcf_pkg::ST_WRITE: begin
                wr_en = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        item_next     = item_reg;
        epoch_next    = epoch_reg;
        clr_idx_next  = clr_idx_reg;
        step_next     = step_reg;
        n_next        = n_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        if (accept) begin
            item_next.op      = s_tuser[1:0];
            item_next.label   = s_tdata[9:0];
            item_next.blue    = s_tdata[17:10];
            item_next.green   = s_tdata[25:18];
            item_next.red     = s_tdata[33:26];
            item_next.contour = s_tuser[2];
            if (s_tuser[1:0] == rmcf_pkg::OP_CLEAR) begin
                epoch_next = (epoch_reg == rmcf_pkg::EPOCH_LAST) ? epoch_reg
                                                                  : epoch_reg + 1'b1;
                clr_idx_next = '0;
            end
        end

        if (state_reg == rmcf_pkg::ST_CLEAR) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == rmcf_pkg::LABEL_LAST) begin
                epoch_next = rmcf_pkg::EPOCH_BITS'(1);
            end
        end

        if (lane_ctrl.load) begin
            n_next    = n_new;
            step_next = '0;
        end else if (lane_ctrl.step) begin
            step_next = step_reg + 1'b1;
        end

        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = item_reg.contour ? '0 : {cur_red, cur_green, cur_blue};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rmcf_pkg::ST_CLEAR;
            epoch_reg    <= rmcf_pkg::EPOCH_BITS'(1);
            clr_idx_reg  <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_idx_reg  <= clr_idx_next;
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        n_reg       <= n_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    rmcf_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (s_tdata[9:0]),
        .rd_data (rd_data)
    );

    rmcf_div_lane u_lane_blue (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .mean    (cur_blue),
        .pixel   (item_reg.blue),
        .divisor (n_reg),
        .result  (res_blue)
    );

    rmcf_div_lane u_lane_green (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .mean    (cur_green),
        .pixel   (item_reg.green),
        .divisor (n_reg),
        .result  (res_green)
    );

    rmcf_div_lane u_lane_red (
        .aclk    (aclk),
        .ctrl    (lane_ctrl),
        .mean    (cur_red),
        .pixel   (item_reg.red),
        .divisor (n_reg),
        .result  (res_red)
    );

endmodule

// ===== rtl/rmcf_table.sv =====
// Label table memory: one entry per label holding frame tag, count and mean colour.
// Depends on rmcf_pkg for the entry type and depth.
`timescale 1ns / 1ps

module rmcf_table (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [rmcf_pkg::LABEL_BITS-1:0] wr_addr,
    input  rmcf_pkg::entry_t                wr_data,
    input  logic                            rd_en,
    input  logic [rmcf_pkg::LABEL_BITS-1:0] rd_addr,
    output rmcf_pkg::entry_t                rd_data
);

    rmcf_pkg::entry_t mem [rmcf_pkg::LABEL_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rmcf_div_lane.sv =====
// Bit-serial mean update for one colour channel: mean + floor((pixel - mean) / n).
// The difference magnitude shifts out one bit per cycle into a restoring divider.
// Depends on rmcf_pkg.
`timescale 1ns / 1ps

module rmcf_div_lane (
    input  logic                            aclk,
    input  rmcf_pkg::lane_ctrl_t            ctrl,
    input  logic [rmcf_pkg::CHAN_BITS-1:0]  mean,
    input  logic [rmcf_pkg::CHAN_BITS-1:0]  pixel,
    input  logic [rmcf_pkg::COUNT_BITS-1:0] divisor,
    output logic [rmcf_pkg::CHAN_BITS-1:0]  result
);

    localparam int CB = rmcf_pkg::CHAN_BITS;
    localparam int WB = rmcf_pkg::COUNT_BITS + CB + 1;

    logic [CB-1:0] mean_reg, mean_next;
    logic          neg_reg, neg_next;
    logic [CB-1:0] dig_reg, dig_next;
    logic [CB-1:0] rem_reg, rem_next;
    logic [CB-1:0] quo_reg, quo_next;
    logic [CB:0]   trial;
    logic [WB-1:0] trial_ext;
    logic [WB-1:0] div_ext;
    logic [WB-1:0] diff;
    logic          fits;

    always_comb begin
        trial     = {rem_reg, dig_reg[CB-1]};
        trial_ext = WB'(trial);
        div_ext   = WB'(divisor);
        diff      = trial_ext - div_ext;
        fits      = trial_ext >= div_ext;
    end

    always_comb begin
        mean_next = mean_reg;
        neg_next  = neg_reg;
        dig_next  = dig_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctrl.load) begin
            mean_next = mean;
            neg_next  = pixel < mean;
            dig_next  = (pixel < mean) ? (mean - pixel) : (pixel - mean);
            rem_next  = '0;
            quo_next  = '0;
        end else if (ctrl.step) begin
            dig_next = {dig_reg[CB-2:0], 1'b0};
            rem_next = fits ? diff[CB-1:0] : trial[CB-1:0];
            quo_next = {quo_reg[CB-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        mean_reg <= mean_next;
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    // A negative difference rounds towards minus infinity, so a non-zero remainder
    // takes one more off the mean.
    assign result = neg_reg ? (mean_reg - quo_reg - CB'(rem_reg != '0))
                            : (mean_reg + quo_reg);

endmodule
